// ===== rtl/core/tlpc_pkg.sv =====
// shared types and constants for the touch long-press classifier
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package tlpc_pkg;

    // field widths
    localparam int OP_W    = 3;
    localparam int POS_W   = 16;
    localparam int SEC_W   = 32;
    localparam int USEC_W  = 20;
    localparam int HELD_W  = 32;
    localparam int SENS_W  = 16;
    localparam int CIDX_W  = 2;
    localparam int CDATA_W = 32;

    // duration arithmetic widths
    localparam int DSEC_W  = SEC_W + 1;
    localparam int DUS_W   = USEC_W + 2;
    localparam int PROD_W  = DSEC_W + USEC_W;
    localparam int TOTAL_W = PROD_W + 1;

    localparam logic [USEC_W-1:0] USEC_PER_SEC = USEC_W'(1000000);

    // register reset values
    localparam logic [HELD_W-1:0] CLICK_TIME_RST = HELD_W'(500000);
    localparam logic [HELD_W-1:0] HOLD_TIME_RST  = HELD_W'(4000000);
    localparam logic [SENS_W-1:0] SENS_RST       = SENS_W'(8);

    // event kinds
    localparam logic [OP_W-1:0] OP_DOWN = 3'd0;
    localparam logic [OP_W-1:0] OP_UP   = 3'd1;
    localparam logic [OP_W-1:0] OP_POSX = 3'd2;
    localparam logic [OP_W-1:0] OP_POSY = 3'd3;

    // register indexes
    localparam logic [CIDX_W-1:0] REG_CLICK_TIME = 2'd0;
    localparam logic [CIDX_W-1:0] REG_HOLD_TIME  = 2'd1;
    localparam logic [CIDX_W-1:0] REG_MOVE_SENS  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [POS_W-1:0]  position;
        logic [SEC_W-1:0]  stamp_sec;
        logic [USEC_W-1:0] stamp_usec;
    } tlpc_in_t;

    typedef struct packed {
        logic              button;
        logic [HELD_W-1:0] held_us;
    } tlpc_out_t;

    typedef struct packed {
        logic [HELD_W-1:0] click_time_us;
        logic [HELD_W-1:0] hold_time_us;
        logic [SENS_W-1:0] move_window;
    } tlpc_cfg_t;

    // press measured by the front, seconds and microseconds after borrow
    typedef struct packed {
        logic signed [DSEC_W-1:0] dsec;
        logic signed [DUS_W-1:0]  dus;
    } tlpc_job_t;

endpackage

`default_nettype wire

// ===== rtl/core/tlpc_front.sv =====
// front part: press tracking state, movement check and duration split
// depends on tlpc_pkg; feeds measured presses to the job queue
`timescale 1ns / 1ps
`default_nettype none

module tlpc_front
    import tlpc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  tlpc_in_t       in_data,
    input  tlpc_cfg_t      cfg,
    output logic           job_valid,
    output tlpc_job_t      job,
    input  wire logic      job_ready
);

    logic              armed_reg, armed_next;
    logic [SEC_W-1:0]  start_sec_reg, start_sec_next;
    logic [USEC_W-1:0] start_usec_reg, start_usec_next;
    logic [POS_W-1:0]  first_x_reg, first_x_next;
    logic [POS_W-1:0]  first_y_reg, first_y_next;

    logic              accept;
    logic [POS_W-1:0]  seen;
    logic [POS_W-1:0]  diff;
    logic              moved;
    logic [DSEC_W-1:0] sec_diff;
    logic [DSEC_W-1:0] sec_diff_m1;
    logic              sec_later;
    logic              usec_borrow;
    logic [DUS_W-1:0]  dus_raw;

    // the queue sets the pace of the input side
    assign in_ready = job_ready;
    assign accept   = in_valid && in_ready;

    // movement check against the first-seen value of the axis
    assign seen  = (in_data.operation == OP_POSX) ? first_x_reg : first_y_reg;
    assign diff  = (in_data.position > seen) ? (in_data.position - seen)
                                             : (seen - in_data.position);
    assign moved = (seen != '0) && (diff > cfg.move_window);

    // duration split with borrow, sec - start - 1 built in parallel
    assign sec_diff    = {1'b0, in_data.stamp_sec} - {1'b0, start_sec_reg};
    assign sec_diff_m1 = {1'b0, in_data.stamp_sec} + ~{1'b0, start_sec_reg};
    assign sec_later   = in_data.stamp_sec > start_sec_reg;
    assign usec_borrow = in_data.stamp_usec < start_usec_reg;
    assign dus_raw     = {2'b00, in_data.stamp_usec} - {2'b00, start_usec_reg};

    always_comb
    begin
        job.dsec = $signed((usec_borrow && sec_later) ? sec_diff_m1 : sec_diff);
        job.dus  = $signed(usec_borrow ? (dus_raw + {2'b00, USEC_PER_SEC}) : dus_raw);
    end

    assign job_valid = accept && (in_data.operation == OP_UP) && armed_reg;

    // next state per event kind
    always_comb
    begin
        armed_next      = armed_reg;
        start_sec_next  = start_sec_reg;
        start_usec_next = start_usec_reg;
        first_x_next    = first_x_reg;
        first_y_next    = first_y_reg;
        if (accept)
        begin
            unique case (in_data.operation) inside
                OP_DOWN:
                begin
                    armed_next      = 1'b1;
                    first_x_next    = '0;
                    first_y_next    = '0;
                    start_sec_next  = in_data.stamp_sec;
                    start_usec_next = in_data.stamp_usec;
                end
                OP_UP:
                begin
                    armed_next = 1'b0;
                end
                OP_POSX, OP_POSY:
                begin
                    if (armed_reg)
                    begin
                        // zero means not yet seen
                        if (seen == '0)
                        begin
                            if (in_data.operation == OP_POSX)
                                first_x_next = in_data.position;
                            else
                                first_y_next = in_data.position;
                        end
                        if (moved)
                        begin
                            armed_next      = 1'b0;
                            start_sec_next  = in_data.stamp_sec;
                            start_usec_next = in_data.stamp_usec;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg      <= 1'b0;
            start_sec_reg  <= '0;
            start_usec_reg <= '0;
            first_x_reg    <= '0;
            first_y_reg    <= '0;
        end
        else
        begin
            armed_reg      <= armed_next;
            start_sec_reg  <= start_sec_next;
            start_usec_reg <= start_usec_next;
            first_x_reg    <= first_x_next;
            first_y_reg    <= first_y_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tlpc_queue.sv =====
// short job queue between the front and back parts
// depends on tlpc_pkg for the job type
`timescale 1ns / 1ps
`default_nettype none

module tlpc_queue
    import tlpc_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  tlpc_job_t push_data,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output tlpc_job_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tlpc_job_t        entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // pointer wrap and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ===== rtl/core/tlpc_back.sv =====
// back part: duration scaling, saturation, click classification, result register
// depends on tlpc_pkg; takes jobs from the queue
`timescale 1ns / 1ps
`default_nettype none

module tlpc_back
    import tlpc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic job_valid,
    output logic      job_ready,
    input  tlpc_job_t job,
    input  tlpc_cfg_t cfg,
    output logic      out_valid,
    input  wire logic out_ready,
    output tlpc_out_t out_data
);

    logic                     s1_valid_reg;
    logic signed [PROD_W-1:0] s1_prod_reg;
    logic signed [DUS_W-1:0]  s1_dus_reg;
    logic                     out_valid_reg;
    tlpc_out_t                out_data_reg;

    logic signed [PROD_W-1:0]  prod;
    logic signed [TOTAL_W-1:0] total;
    logic                      negative;
    logic                      saturate;
    logic [HELD_W-1:0]         held;
    logic                      keep;
    logic                      s1_ready;
    logic                      s2_ready;

    // stall chain back from the result register
    assign s2_ready  = !out_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign job_ready = s1_ready;

    // whole seconds to microseconds
    assign prod = $signed({{(PROD_W - DSEC_W){job.dsec[DSEC_W-1]}}, job.dsec})
                * $signed({{(PROD_W - USEC_W){1'b0}}, USEC_PER_SEC});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ready)
            s1_valid_reg <= job_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && job_valid)
        begin
            s1_prod_reg <= prod;
            s1_dus_reg  <= job.dus;
        end
    end

    // total duration, saturation and thresholds
    assign total    = {s1_prod_reg[PROD_W-1], s1_prod_reg}
                    + {{(TOTAL_W - DUS_W){s1_dus_reg[DUS_W-1]}}, s1_dus_reg};
    assign negative = total[TOTAL_W-1];
    assign saturate = |total[TOTAL_W-2:HELD_W];
    assign held     = saturate ? '1 : total[HELD_W-1:0];
    assign keep     = !negative && (held >= cfg.click_time_us);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s2_ready)
            out_valid_reg <= s1_valid_reg && keep;
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            out_data_reg.button  <= held >= cfg.hold_time_us;
            out_data_reg.held_us <= held;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/touch_long_press_classifier.sv =====
// touch long-press classifier: a touch-up beat reaches the result through the
// queue entry, the multiply stage and the result register; one beat accepted per cycle
// while the job queue has room, results leave at one per cycle while out_ready is high
// reset: detector disarmed, coordinates unset, queue and pipeline empty,
// registers at click 500000 us, hold 4000000 us, sensitivity 8
// depends on tlpc_pkg, tlpc_front, tlpc_queue, tlpc_back
`timescale 1ns / 1ps
`default_nettype none

module touch_long_press_classifier
    import tlpc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  tlpc_in_t                in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output tlpc_out_t               out_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [CIDX_W-1:0]  cfg_index,
    input  wire logic [CDATA_W-1:0] cfg_data
);

    tlpc_cfg_t cfg_reg;
    logic      front_job_valid;
    tlpc_job_t front_job;
    logic      queue_push_ready;
    logic      queue_pop_valid;
    tlpc_job_t queue_pop_data;
    logic      back_job_ready;

    // configuration registers, writes always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.click_time_us <= CLICK_TIME_RST;
            cfg_reg.hold_time_us  <= HOLD_TIME_RST;
            cfg_reg.move_window   <= SENS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CLICK_TIME: cfg_reg.click_time_us <= cfg_data;
                REG_HOLD_TIME:  cfg_reg.hold_time_us  <= cfg_data;
                REG_MOVE_SENS:  cfg_reg.move_window   <= cfg_data[SENS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // press tracking
    tlpc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cfg       (cfg_reg),
        .job_valid (front_job_valid),
        .job       (front_job),
        .job_ready (queue_push_ready)
    );

    // decoupling queue
    tlpc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_job_valid),
        .push_ready (queue_push_ready),
        .push_data  (front_job),
        .pop_valid  (queue_pop_valid),
        .pop_ready  (back_job_ready),
        .pop_data   (queue_pop_data)
    );

    // duration and click classification
    tlpc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (queue_pop_valid),
        .job_ready (back_job_ready),
        .job       (queue_pop_data),
        .cfg       (cfg_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
